// ----- rtl/core/sau_pkg.sv -----
// ----------------------------------------------------------------------------
// Stack arithmetic unit package
// Operation codes, result status codes, word widths and the controller state
// type shared by the stack arithmetic unit and its parts.
// ----------------------------------------------------------------------------
`default_nettype none

package sau_pkg;

    localparam int WORD_W   = 32;
    localparam int MODE_W   = 3;
    localparam int STATUS_W = 3;
    localparam int DEPTH_W  = 7;

    localparam logic [MODE_W-1:0] MODE_NOP  = 3'd0;
    localparam logic [MODE_W-1:0] MODE_PUSH = 3'd1;
    localparam logic [MODE_W-1:0] MODE_SWAP = 3'd2;
    localparam logic [MODE_W-1:0] MODE_ADD  = 3'd3;
    localparam logic [MODE_W-1:0] MODE_SUB  = 3'd4;
    localparam logic [MODE_W-1:0] MODE_DIV  = 3'd5;

    localparam logic [STATUS_W-1:0] STAT_OK      = 3'd0;
    localparam logic [STATUS_W-1:0] STAT_SHORT   = 3'd1;
    localparam logic [STATUS_W-1:0] STAT_DIVZERO = 3'd2;
    localparam logic [STATUS_W-1:0] STAT_FULL    = 3'd3;
    localparam logic [STATUS_W-1:0] STAT_HALTED  = 3'd4;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_SWAP2,
        ST_DIVW,
        ST_RESP
    } sau_state_t;

endpackage

`default_nettype wire

// ----- rtl/core/sau_ram.sv -----
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module sau_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ----- rtl/core/sau_div.sv -----
// ----------------------------------------------------------------------------
// Stack arithmetic unit divider
// Signed 32-bit division truncated toward zero, one quotient bit per cycle
// by restoring division on the magnitudes.
// ----------------------------------------------------------------------------
`default_nettype none

module sau_div (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       start,
    input  wire logic [sau_pkg::WORD_W-1:0] num,
    input  wire logic [sau_pkg::WORD_W-1:0] den,
    output logic                            done,
    output logic      [sau_pkg::WORD_W-1:0] quot
);

    import sau_pkg::*;

    localparam int CNT_W = $clog2(WORD_W);

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic              neg_reg, neg_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [WORD_W-1:0] rem_reg, rem_next;
    logic [WORD_W-1:0] quo_reg, quo_next;
    logic [WORD_W-1:0] den_reg, den_next;

    logic [WORD_W:0]   shifted;
    logic [WORD_W:0]   trial;
    logic              take;
    logic [WORD_W-1:0] num_mag;
    logic [WORD_W-1:0] den_mag;

    assign num_mag = num[WORD_W-1] ? (WORD_W'(0) - num) : num;
    assign den_mag = den[WORD_W-1] ? (WORD_W'(0) - den) : den;
    assign shifted = {rem_reg, quo_reg[WORD_W-1]};
    assign trial   = shifted - {1'b0, den_reg};
    assign take    = ~trial[WORD_W];

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        neg_next  = neg_reg;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        den_next  = den_reg;
        if (start)
        begin
            busy_next = 1'b1;
            neg_next  = num[WORD_W-1] ^ den[WORD_W-1];
            cnt_next  = '0;
            rem_next  = '0;
            quo_next  = num_mag;
            den_next  = den_mag;
        end
        else if (busy_reg)
        begin
            rem_next = take ? trial[WORD_W-1:0] : shifted[WORD_W-1:0];
            quo_next = {quo_reg[WORD_W-2:0], take};
            cnt_next = cnt_reg + CNT_W'(1);
            if (cnt_reg == CNT_W'(WORD_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        neg_reg <= neg_next;
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        den_reg <= den_next;
    end

    assign done = done_reg;
    assign quot = neg_reg ? (WORD_W'(0) - quo_reg) : quo_reg;

endmodule

`default_nettype wire

// ----- rtl/core/stack_arith_unit.sv -----
// ----------------------------------------------------------------------------
// Stack arithmetic unit
//
//   Channel  Direction  Contents
//   s_*      in         tuser: mode; tdata: value
//   m_*      out        tdata: status, top_value, depth
//
// Push, nop, halted and error words go idle to resp; add and sub via exec,
// swap via exec and swap2, div via exec and the one-bit-per-cycle divider.
// The stack lives in one RAM; the top word is also kept in a register.
// Reset clears the state, depth, halt flag and output valid, not the RAM.
// A result waits in the output register while the next word is accepted;
// a later result waits for that register to empty.
// ----------------------------------------------------------------------------
`default_nettype none

module stack_arith_unit #(
    parameter int STACK_DEPTH = 64
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [31:0] s_tdata,   // [31:0] value
    input  wire logic [2:0]  s_tuser,   // [2:0] mode
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic      [47:0] m_tdata    // [2:0] status, [34:3] top_value,
                                        // [41:35] depth, [47:42] zero
);

    import sau_pkg::*;

    localparam int AW = $clog2(STACK_DEPTH);
    localparam int CW = $clog2(STACK_DEPTH + 1);

    sau_state_t           state_reg, state_next;
    logic [CW-1:0]        count_reg, count_next;
    logic                 halted_reg, halted_next;
    logic [WORD_W-1:0]    top_reg, top_next;
    logic [MODE_W-1:0]    mode_reg, mode_next;
    logic [STATUS_W-1:0]  status_reg, status_next;
    logic                 m_valid_reg, m_valid_next;
    logic [STATUS_W-1:0]  m_status_reg, m_status_next;
    logic [WORD_W-1:0]    m_top_reg, m_top_next;
    logic [DEPTH_W-1:0]   m_depth_reg, m_depth_next;

    logic                 s_accept;
    logic                 slot_free;
    logic                 op_binary;
    logic                 stack_full;
    logic                 stack_short;
    logic [CW-1:0]        cnt_m1;
    logic [CW-1:0]        cnt_m2;
    logic [CW+DEPTH_W-1:0] depth_ext;

    logic                 mem_we;
    logic [AW-1:0]        mem_waddr;
    logic [WORD_W-1:0]    mem_wdata;
    logic                 mem_re;
    logic [WORD_W-1:0]    mem_rdata;
    logic                 div_start;
    logic                 div_done;
    logic [WORD_W-1:0]    div_quot;
    logic [WORD_W-1:0]    alu_sum;
    logic [WORD_W-1:0]    alu_diff;

    assign s_tready    = (state_reg == ST_IDLE);
    assign s_accept    = s_tvalid && s_tready;
    assign slot_free   = !m_valid_reg || m_tready;
    assign op_binary   = (s_tuser == MODE_SWAP) || (s_tuser == MODE_ADD) ||
                         (s_tuser == MODE_SUB) || (s_tuser == MODE_DIV);
    assign stack_full  = (count_reg >= CW'(STACK_DEPTH));
    assign stack_short = (count_reg < CW'(2));
    assign cnt_m1      = count_reg - CW'(1);
    assign cnt_m2      = count_reg - CW'(2);
    assign depth_ext   = {{DEPTH_W{1'b0}}, count_reg};
    assign alu_sum     = mem_rdata + top_reg;
    assign alu_diff    = mem_rdata - top_reg;

    sau_ram #(
        .WIDTH(WORD_W),
        .DEPTH(STACK_DEPTH)
    ) u_stack_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (cnt_m2[AW-1:0]),
        .rdata (mem_rdata)
    );

    sau_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (mem_rdata),
        .den   (top_reg),
        .done  (div_done),
        .quot  (div_quot)
    );

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (s_accept)
                begin
                    if (!halted_reg && op_binary && !stack_short &&
                        !((s_tuser == MODE_DIV) && (top_reg == '0)))
                    begin
                        state_next = ST_EXEC;
                    end
                    else
                    begin
                        state_next = ST_RESP;
                    end
                end
            end
            ST_EXEC:
            begin
                case (mode_reg)
                    MODE_SWAP: state_next = ST_SWAP2;
                    MODE_DIV:  state_next = ST_DIVW;
                    default:   state_next = ST_RESP;
                endcase
            end
            ST_SWAP2:
            begin
                state_next = ST_RESP;
            end
            ST_DIVW:
            begin
                if (div_done)
                begin
                    state_next = ST_RESP;
                end
            end
            ST_RESP:
            begin
                if (slot_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        count_next    = count_reg;
        halted_next   = halted_reg;
        top_next      = top_reg;
        mode_next     = mode_reg;
        status_next   = status_reg;
        m_valid_next  = m_valid_reg && !m_tready;
        m_status_next = m_status_reg;
        m_top_next    = m_top_reg;
        m_depth_next  = m_depth_reg;
        mem_we        = 1'b0;
        mem_waddr     = cnt_m2[AW-1:0];
        mem_wdata     = top_reg;
        mem_re        = 1'b0;
        div_start     = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (s_accept)
                begin
                    mode_next   = s_tuser;
                    status_next = STAT_OK;
                    if (halted_reg)
                    begin
                        status_next = STAT_HALTED;
                    end
                    else if (s_tuser == MODE_PUSH)
                    begin
                        if (stack_full)
                        begin
                            status_next = STAT_FULL;
                            halted_next = 1'b1;
                        end
                        else
                        begin
                            mem_we     = 1'b1;
                            mem_waddr  = count_reg[AW-1:0];
                            mem_wdata  = s_tdata;
                            top_next   = s_tdata;
                            count_next = count_reg + CW'(1);
                        end
                    end
                    else if (op_binary)
                    begin
                        if (stack_short)
                        begin
                            status_next = STAT_SHORT;
                            halted_next = 1'b1;
                        end
                        else if ((s_tuser == MODE_DIV) && (top_reg == '0))
                        begin
                            status_next = STAT_DIVZERO;
                            halted_next = 1'b1;
                        end
                        else
                        begin
                            mem_re = 1'b1;
                        end
                    end
                end
            end
            ST_EXEC:
            begin
                case (mode_reg)
                    MODE_SWAP:
                    begin
                        mem_we    = 1'b1;
                        mem_wdata = top_reg;
                        top_next  = mem_rdata;
                    end
                    MODE_ADD:
                    begin
                        mem_we     = 1'b1;
                        mem_wdata  = alu_sum;
                        top_next   = alu_sum;
                        count_next = cnt_m1;
                    end
                    MODE_SUB:
                    begin
                        mem_we     = 1'b1;
                        mem_wdata  = alu_diff;
                        top_next   = alu_diff;
                        count_next = cnt_m1;
                    end
                    MODE_DIV:
                    begin
                        div_start = 1'b1;
                    end
                    default:
                    begin
                        mem_we = 1'b0;
                    end
                endcase
            end
            ST_SWAP2:
            begin
                mem_we    = 1'b1;
                mem_waddr = cnt_m1[AW-1:0];
                mem_wdata = top_reg;
            end
            ST_DIVW:
            begin
                if (div_done)
                begin
                    mem_we     = 1'b1;
                    mem_wdata  = div_quot;
                    top_next   = div_quot;
                    count_next = cnt_m1;
                end
            end
            ST_RESP:
            begin
                if (slot_free)
                begin
                    m_valid_next  = 1'b1;
                    m_status_next = status_reg;
                    m_top_next    = (count_reg == '0) ? '0 : top_reg;
                    m_depth_next  = depth_ext[DEPTH_W-1:0];
                end
            end
            default:
            begin
                mem_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            halted_reg  <= 1'b0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            halted_reg  <= halted_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        top_reg      <= top_next;
        mode_reg     <= mode_next;
        status_reg   <= status_next;
        m_status_reg <= m_status_next;
        m_top_reg    <= m_top_next;
        m_depth_reg  <= m_depth_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {6'b0, m_depth_reg, m_top_reg, m_status_reg};

endmodule

`default_nettype wire

// ----- rtl/core/stack_arith_unit_checker.sv -----
// ----------------------------------------------------------------------------
// Stack arithmetic unit checker
// Port-level assertions on the stack arithmetic unit, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module stack_arith_unit_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        s_tvalid,
    input wire logic        s_tready,
    input wire logic [31:0] s_tdata,
    input wire logic [2:0]  s_tuser,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [47:0] m_tdata
);

    import sau_pkg::*;

    logic                halt_seen_reg;
    logic [STATUS_W-1:0] status;

    assign status = m_tdata[2:0];

    // Once an error word has been delivered, every later word reports halted.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            halt_seen_reg <= 1'b0;
        end
        else if (m_tvalid && m_tready && (status != STAT_OK))
        begin
            halt_seen_reg <= 1'b1;
        end
    end

    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result word changed while stalled");

    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("second word accepted while one is in progress");

    a_empty_top: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tdata[41:35] == 7'd0) |-> (m_tdata[34:3] == 32'd0))
        else $error("empty stack reports a non-zero top word");

    a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (status <= STAT_HALTED))
        else $error("status code out of range");

    a_halt_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        halt_seen_reg && m_tvalid |-> (status == STAT_HALTED))
        else $error("word after an error does not report halted");

    logic unused_ok;
    assign unused_ok = ^{s_tdata, s_tuser};

endmodule

bind stack_arith_unit stack_arith_unit_checker u_checker (.*);

`default_nettype wire

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Stack arithmetic unit testbench
// A short directed table covers the extremes, wrapping, division overflow,
// truncation and the unused modes. Well-formed random operation sequences
// follow, filling and draining the stack. The run ends with one randomly
// chosen error and a few words sent while the unit is halted. Every result
// word is checked against a fixed table entry or the bench's own predictor.
// ----------------------------------------------------------------------------

module testbench;
    import sau_pkg::*;

    localparam int DEPTH        = 64;
    localparam int RANDOM_WORDS = 1200;
    localparam int CALM_WORDS   = 150;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 60;

    localparam logic [MODE_W-1:0] MODE_UNUSED_A = 3'd6;
    localparam logic [MODE_W-1:0] MODE_UNUSED_B = 3'd7;

    localparam int ERR_SHORT   = 0;
    localparam int ERR_DIVZERO = 1;
    localparam int ERR_FULL    = 2;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [WORD_W-1:0]   top_value;
        logic [DEPTH_W-1:0]  depth;
    } stack_result_t;

    typedef struct {
        logic [MODE_W-1:0] mode;
        logic [WORD_W-1:0] value;
        bit                fixed;
        stack_result_t     result;
    } table_row_t;

    logic        clk      = 1'b0;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata  = '0;
    logic [2:0]  s_tuser  = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [47:0] m_tdata;

    stack_arith_unit #(
        .STACK_DEPTH(DEPTH)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .s_tuser(s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    logic [WORD_W-1:0] pred_stack [DEPTH];
    int unsigned       pred_depth = 0;
    bit                pred_halt  = 1'b0;

    stack_result_t pending_results [$];
    stack_result_t seen_result;
    stack_result_t due_result;
    table_row_t    directed_rows [25];

    bit          idle_enable = 1'b1;
    int          faults      = 0;
    int          words_sent  = 0;
    int          words_back  = 0;
    int          deepest     = 0;
    int          op_count [8];
    int          stall_left  = 0;
    int          cycle_count = 0;
    int          error_kind;
    logic        ready_next;

    function automatic stack_result_t stack_op_result(input logic [MODE_W-1:0] mode,
                                                      input logic [WORD_W-1:0] value);
        logic [WORD_W-1:0] upper, lower, outcome, num_mag, den_mag, quot;
        stack_result_t     res;
        res.status = STAT_OK;
        outcome    = '0;
        if (pred_halt)
        begin
            res.status = STAT_HALTED;
        end
        else if (mode == MODE_PUSH)
        begin
            if (pred_depth >= DEPTH)
            begin
                res.status = STAT_FULL;
                pred_halt  = 1'b1;
            end
            else
            begin
                pred_stack[pred_depth] = value;
                pred_depth++;
            end
        end
        else if (mode >= MODE_SWAP && mode <= MODE_DIV)
        begin
            if (pred_depth < 2)
            begin
                res.status = STAT_SHORT;
                pred_halt  = 1'b1;
            end
            else
            begin
                upper = pred_stack[pred_depth-1];
                lower = pred_stack[pred_depth-2];
                if (mode == MODE_SWAP)
                begin
                    pred_stack[pred_depth-1] = lower;
                    pred_stack[pred_depth-2] = upper;
                end
                else if (mode == MODE_DIV && upper == '0)
                begin
                    res.status = STAT_DIVZERO;
                    pred_halt  = 1'b1;
                end
                else
                begin
                    case (mode)
                        MODE_ADD: outcome = lower + upper;
                        MODE_SUB: outcome = lower - upper;
                        default:
                        begin
                            num_mag = lower[WORD_W-1] ? -lower : lower;
                            den_mag = upper[WORD_W-1] ? -upper : upper;
                            quot    = num_mag / den_mag;
                            outcome = (lower[WORD_W-1] ^ upper[WORD_W-1]) ? -quot : quot;
                        end
                    endcase
                    pred_depth--;
                    pred_stack[pred_depth-1] = outcome;
                end
            end
        end
        res.top_value = (pred_depth > 0) ? pred_stack[pred_depth-1] : '0;
        res.depth     = DEPTH_W'(pred_depth);
        return res;
    endfunction

    function automatic logic [WORD_W-1:0] random_word();
        case ($urandom_range(0, 7))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return {$urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0000_0000};
            3, 4: return $urandom_range(0, 40) - 20;
            default: return $urandom();
        endcase
    endfunction

    function automatic logic [MODE_W-1:0] pick_binary_op();
        case ($urandom_range(0, 3))
            0: return MODE_SWAP;
            1: return MODE_ADD;
            2: return MODE_SUB;
            default: return MODE_DIV;
        endcase
    endfunction

    task automatic send_word(input logic [MODE_W-1:0] mode, input logic [WORD_W-1:0] value,
                             input bit fixed = 1'b0, input stack_result_t fixed_result = '0);
        int            gap;
        stack_result_t predicted;
        if (idle_enable && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 4);
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= mode;
        s_tdata  <= value;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        predicted = stack_op_result(mode, value);
        pending_results.push_back(fixed ? fixed_result : predicted);
        words_sent++;
        op_count[mode]++;
        if (pred_depth > deepest) deepest = pred_depth;
    endtask

    task automatic random_step(input int push_pct);
        int                roll;
        logic [MODE_W-1:0] op;
        roll = $urandom_range(0, 99);
        if (roll < 2)
            op = MODE_NOP;
        else if (roll < 4)
            op = MODE_UNUSED_A;
        else if (roll < 6)
            op = MODE_UNUSED_B;
        else if (pred_depth < 2 || (roll < 6 + push_pct && pred_depth < DEPTH))
            op = MODE_PUSH;
        else
        begin
            op = pick_binary_op();
            if (op == MODE_DIV && pred_stack[pred_depth-1] == '0) op = MODE_SUB;
        end
        send_word(op, (op == MODE_PUSH) ? random_word() : $urandom());
    endtask

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            seen_result.status    = m_tdata[2:0];
            seen_result.top_value = m_tdata[34:3];
            seen_result.depth     = m_tdata[41:35];
            if (pending_results.size() == 0)
            begin
                $error("unexpected result word: status %0d, top_value %0d, depth %0d",
                       seen_result.status, $signed(seen_result.top_value), seen_result.depth);
                faults++;
            end
            else
            begin
                due_result = pending_results.pop_front();
                words_back++;
                if (seen_result.status !== due_result.status)
                begin
                    $error("status: expected %0d, got %0d",
                           due_result.status, seen_result.status);
                    faults++;
                end
                if (seen_result.top_value !== due_result.top_value)
                begin
                    $error("top_value: expected %0d, got %0d",
                           $signed(due_result.top_value), $signed(seen_result.top_value));
                    faults++;
                end
                if (seen_result.depth !== due_result.depth)
                begin
                    $error("depth: expected %0d, got %0d",
                           due_result.depth, seen_result.depth);
                    faults++;
                end
            end
        end
        ready_next = 1'b1;
        if (stall_left > 0)
        begin
            ready_next = 1'b0;
            stall_left--;
        end
        else if (idle_enable && $urandom_range(0, 4) == 0)
        begin
            ready_next = 1'b0;
            stall_left = $urandom_range(1, 4) - 1;
        end
        m_tready <= ready_next;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Run stopped at the cycle limit with %0d results outstanding.",
                     pending_results.size());
            $display("** stack_arith_unit: FAILED **");
            $finish;
        end
    end

    initial
    begin
        foreach (op_count[k]) op_count[k] = 0;
        directed_rows = '{
            '{MODE_NOP,      32'h0000_0000, 1'b1, '{STAT_OK, 32'h0000_0000, 7'd0}},
            '{MODE_UNUSED_A, 32'hFFFF_FFFF, 1'b1, '{STAT_OK, 32'h0000_0000, 7'd0}},
            '{MODE_PUSH,     32'h7FFF_FFFF, 1'b1, '{STAT_OK, 32'h7FFF_FFFF, 7'd1}},
            '{MODE_PUSH,     32'h0000_0001, 1'b1, '{STAT_OK, 32'h0000_0001, 7'd2}},
            '{MODE_ADD,      32'hA5A5_5A5A, 1'b1, '{STAT_OK, 32'h8000_0000, 7'd1}},
            '{MODE_PUSH,     32'hFFFF_FFFF, 1'b1, '{STAT_OK, 32'hFFFF_FFFF, 7'd2}},
            '{MODE_DIV,      32'h5A5A_A5A5, 1'b1, '{STAT_OK, 32'h8000_0000, 7'd1}},
            '{MODE_PUSH,     32'h0000_0001, 1'b1, '{STAT_OK, 32'h0000_0001, 7'd2}},
            '{MODE_SUB,      32'hFFFF_0000, 1'b1, '{STAT_OK, 32'h7FFF_FFFF, 7'd1}},
            '{MODE_PUSH,     32'hFFFF_FFF9, 1'b0, '0},
            '{MODE_PUSH,     32'h0000_0002, 1'b0, '0},
            '{MODE_DIV,      32'h0000_FFFF, 1'b0, '0},
            '{MODE_SWAP,     32'h1234_5678, 1'b1, '{STAT_OK, 32'h7FFF_FFFF, 7'd2}},
            '{MODE_DIV,      32'h8765_4321, 1'b0, '0},
            '{MODE_PUSH,     32'h0000_0005, 1'b0, '0},
            '{MODE_PUSH,     32'hFFFF_FFFE, 1'b0, '0},
            '{MODE_DIV,      32'hFFFF_FFFF, 1'b0, '0},
            '{MODE_SUB,      32'h0000_0000, 1'b0, '0},
            '{MODE_UNUSED_B, 32'hFFFF_FFFF, 1'b0, '0},
            '{MODE_PUSH,     32'h0000_0000, 1'b0, '0},
            '{MODE_ADD,      32'hC3C3_3C3C, 1'b0, '0},
            '{MODE_PUSH,     32'h8000_0000, 1'b0, '0},
            '{MODE_PUSH,     32'h8000_0000, 1'b0, '0},
            '{MODE_ADD,      32'h0F0F_F0F0, 1'b1, '{STAT_OK, 32'h0000_0000, 7'd2}},
            '{MODE_SWAP,     32'hF0F0_0F0F, 1'b0, '0}
        };

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        foreach (directed_rows[r])
            send_word(directed_rows[r].mode, directed_rows[r].value,
                      directed_rows[r].fixed, directed_rows[r].result);

        for (int i = 0; i < RANDOM_WORDS; i++)
        begin
            if (i == RANDOM_WORDS - CALM_WORDS) idle_enable = 1'b0;
            case ((i / 150) % 3)
                0: random_step(70);
                1: random_step(25);
                default: random_step(45);
            endcase
        end

        error_kind = $urandom_range(ERR_SHORT, ERR_FULL);
        case (error_kind)
            ERR_SHORT:
            begin
                while (pred_depth > 1) send_word(MODE_ADD, $urandom());
                send_word(pick_binary_op(), $urandom());
            end
            ERR_DIVZERO:
            begin
                if (pred_depth >= DEPTH) send_word(MODE_SUB, $urandom());
                if (pred_depth == 0) send_word(MODE_PUSH, random_word());
                send_word(MODE_PUSH, '0);
                send_word(MODE_DIV, $urandom());
            end
            default:
            begin
                while (pred_depth < DEPTH) send_word(MODE_PUSH, random_word());
                send_word(MODE_PUSH, random_word());
            end
        endcase
        repeat (6) send_word(MODE_W'($urandom_range(0, 7)), $urandom());
        s_tvalid <= 1'b0;

        while (pending_results.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Sent %0d words and checked %0d results; the stack reached depth %0d.",
                 words_sent, words_back, deepest);
        $display("Ops: nop %0d push %0d swap %0d add %0d sub %0d div %0d unused %0d; %s",
                 op_count[MODE_NOP], op_count[MODE_PUSH], op_count[MODE_SWAP],
                 op_count[MODE_ADD], op_count[MODE_SUB], op_count[MODE_DIV],
                 op_count[MODE_UNUSED_A] + op_count[MODE_UNUSED_B],
                 (error_kind == ERR_SHORT)   ? "ended on a short stack." :
                 (error_kind == ERR_DIVZERO) ? "ended on a zero divisor." :
                                               "ended on a full stack.");
        if (faults == 0)
            $display("** stack_arith_unit: PASSED **");
        else
            $display("** stack_arith_unit: FAILED **");
        $finish;
    end

endmodule

// ----- stack_arith_unit.f -----
rtl/core/sau_pkg.sv
rtl/core/sau_ram.sv
rtl/core/sau_div.sv
rtl/core/stack_arith_unit.sv
rtl/core/stack_arith_unit_checker.sv
tb/testbench.sv
